/* rtl/fbpa_pkg.sv */
package fbpa_pkg;

	// Pool geometry
	localparam int BLOCK_COUNT = 1024;
	localparam int BLOCK_BYTES = 2048;

	// Field widths
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 3;
	localparam int BLK_W    = $clog2(BLOCK_COUNT);
	localparam int OFS_W    = $clog2(BLOCK_BYTES);
	localparam int CNT_W    = $clog2(BLOCK_COUNT + 1);

	// Limits used by the request checks
	localparam logic [LEN_W:0]  LEN_LIMIT  = (LEN_W + 1)'(BLOCK_BYTES);
	localparam logic [ADDR_W:0] POOL_SPAN  = (ADDR_W + 1)'(BLOCK_COUNT * BLOCK_BYTES);
	localparam logic [CNT_W-1:0] DEPTH_FULL = CNT_W'(BLOCK_COUNT);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_TOO_BIG = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_OUTSIDE = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

endpackage

/* rtl/fixed_block_pool_allocator.sv */
// Channel    Direction  Signals                                        Transaction
// config     in         cfg_valid, cfg_ready, pool_base                cfg_valid && cfg_ready
// request    in         start, busy, mode, request_length,             start && !busy
//                       free_address
// result     out        done, status, block_address, blocks_in_use     done (one cycle)
//
// One request is taken every cycle; busy stays low and cfg_ready stays high.
// The result appears with done after the request passes the free-stack RAM read
// and then the address add into the output register.
// Stack pointer and in-use count update at acceptance, so a push is visible to the next pop.
// Reset needs no clearing pass: a low-water mark marks stack entries never written,
// which read as their own index. The receiver cannot stall the result.
module fixed_block_pool_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fbpa_pkg::ADDR_W-1:0]   pool_base,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [fbpa_pkg::LEN_W-1:0]    request_length,
	input  logic [fbpa_pkg::ADDR_W-1:0]   free_address,
	output logic                          done,
	output logic [fbpa_pkg::STATUS_W-1:0] status,
	output logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	output logic [fbpa_pkg::CNT_W-1:0]    blocks_in_use
);

	logic [fbpa_pkg::ADDR_W-1:0] pool_base_q;
	logic [fbpa_pkg::CNT_W-1:0]  depth_q;
	logic [fbpa_pkg::CNT_W-1:0]  low_mark_q;
	logic [fbpa_pkg::CNT_W-1:0]  used_cnt_q;

	logic                        accept;
	logic                        too_big;
	logic                        outside;
	logic                        empty;
	logic                        full;
	logic                        do_pop;
	logic                        do_push;
	logic                        fresh;
	logic [fbpa_pkg::ADDR_W-1:0] offset;
	logic [fbpa_pkg::CNT_W-1:0]  top_idx;
	fbpa_pkg::status_t           status_d;

	logic                        valid_s1;
	logic                        alloc_s1;
	logic                        fresh_s1;
	logic [fbpa_pkg::BLK_W-1:0]  idx_s1;
	logic [fbpa_pkg::CNT_W-1:0]  used_s1;
	fbpa_pkg::status_t           status_s1;

	logic [fbpa_pkg::BLK_W-1:0]  rd_blk;
	logic [fbpa_pkg::BLK_W-1:0]  blk;
	logic [fbpa_pkg::ADDR_W-1:0] blk_ofs;
	logic [fbpa_pkg::ADDR_W-1:0] addr_d;

	logic                        done_q;
	fbpa_pkg::status_t           status_q;
	logic [fbpa_pkg::ADDR_W-1:0] addr_q;
	logic [fbpa_pkg::CNT_W-1:0]  inuse_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Hold the pool base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pool_base_q <= pool_base;
		end
	end

	// Check the request against the limits and the stack state
	assign offset  = free_address - pool_base_q;
	assign too_big = {1'b0, request_length} > fbpa_pkg::LEN_LIMIT;
	assign outside = {1'b0, offset} >= fbpa_pkg::POOL_SPAN;
	assign empty   = depth_q == '0;
	assign full    = depth_q == fbpa_pkg::DEPTH_FULL;
	assign do_pop  = accept && !mode && !too_big && !empty;
	assign do_push = accept && mode && !outside && !full;
	assign top_idx = depth_q - fbpa_pkg::CNT_W'(1);
	assign fresh   = depth_q == low_mark_q;

	always_comb begin
		if (!mode) begin
			if (too_big) begin
				status_d = fbpa_pkg::ST_TOO_BIG;
			end else if (empty) begin
				status_d = fbpa_pkg::ST_EMPTY;
			end else begin
				status_d = fbpa_pkg::ST_OK;
			end
		end else begin
			if (outside) begin
				status_d = fbpa_pkg::ST_OUTSIDE;
			end else if (full) begin
				status_d = fbpa_pkg::ST_FULL;
			end else begin
				status_d = fbpa_pkg::ST_OK;
			end
		end
	end

	// Advance the stack pointer, low-water mark and in-use count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= fbpa_pkg::DEPTH_FULL;
			low_mark_q <= fbpa_pkg::DEPTH_FULL;
			used_cnt_q <= '0;
		end else if (do_pop) begin
			depth_q    <= top_idx;
			used_cnt_q <= used_cnt_q + fbpa_pkg::CNT_W'(1);
			if (fresh) begin
				low_mark_q <= top_idx;
			end
		end else if (do_push) begin
			depth_q    <= depth_q + fbpa_pkg::CNT_W'(1);
			used_cnt_q <= used_cnt_q - fbpa_pkg::CNT_W'(1);
		end
	end

	// Free stack: push writes at the pointer, pop reads just below it
	fbpa_ram #(
		.WIDTH(fbpa_pkg::BLK_W),
		.DEPTH(fbpa_pkg::BLOCK_COUNT)
	) u_stack (
		.clk    (clk),
		.wr_en  (do_push),
		.wr_addr(depth_q[fbpa_pkg::BLK_W-1:0]),
		.wr_data(offset[fbpa_pkg::OFS_W +: fbpa_pkg::BLK_W]),
		.rd_addr(top_idx[fbpa_pkg::BLK_W-1:0]),
		.rd_data(rd_blk)
	);

	// Stage 1 control, waiting on the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		alloc_s1  <= do_pop;
		fresh_s1  <= fresh;
		idx_s1    <= top_idx[fbpa_pkg::BLK_W-1:0];
		status_s1 <= status_d;
		if (do_pop) begin
			used_s1 <= used_cnt_q + fbpa_pkg::CNT_W'(1);
		end else if (do_push) begin
			used_s1 <= used_cnt_q - fbpa_pkg::CNT_W'(1);
		end else begin
			used_s1 <= used_cnt_q;
		end
	end

	// Drop the RAM data for entries never written since reset
	assign blk     = fresh_s1 ? idx_s1 : rd_blk;
	assign blk_ofs = fbpa_pkg::ADDR_W'({blk, {fbpa_pkg::OFS_W{1'b0}}});
	assign addr_d  = alloc_s1 ? pool_base_q + blk_ofs : '0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_s1;
		addr_q   <= addr_d;
		inuse_q  <= used_s1;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign block_address = addr_q;
	assign blocks_in_use = inuse_q;

`ifndef SYNTHESIS
	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q + used_cnt_q) == fbpa_pkg::DEPTH_FULL)
		else $error("stack depth and in-use count out of balance");

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		low_mark_q <= depth_q)
		else $error("low-water mark above stack pointer");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |-> depth_q < fbpa_pkg::DEPTH_FULL)
		else $error("push onto a full stack");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result missing two cycles after acceptance");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != fbpa_pkg::ST_OK)) |-> block_address == '0)
		else $error("failed request returned a nonzero address");
`endif

endmodule

/* rtl/fbpa_ram.sv */
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
